[src/qbv_pkg.sv]
package qbv_pkg;

    localparam int unsigned IN_W  = 24;
    localparam int unsigned OUT_W = 16;

    // 1.0 in Q2.30.
    localparam logic [30:0] ONE30 = 31'd1073741824;

    // A cosine magnitude above this, with a negative sign, counts as opposite.
    localparam logic [30:0] OPP_LIM = ONE30 - 31'd1073742;

    // Squared axis length (Q60) below which the second axis is used.
    localparam logic [61:0] AXIS_MIN_SQ = 62'd115292150460685;

    // 1.0 in Q2.14.
    localparam logic [15:0] Q14_ONE = 16'd16384;

endpackage

[src/qbv_pair_if.sv]
interface qbv_pair_if;
    logic                                valid;
    logic                                ready;
    logic signed [qbv_pkg::IN_W-1:0]     start_x;
    logic signed [qbv_pkg::IN_W-1:0]     start_y;
    logic signed [qbv_pkg::IN_W-1:0]     start_z;
    logic signed [qbv_pkg::IN_W-1:0]     dest_x;
    logic signed [qbv_pkg::IN_W-1:0]     dest_y;
    logic signed [qbv_pkg::IN_W-1:0]     dest_z;

    modport source (output valid, start_x, start_y, start_z, dest_x, dest_y, dest_z,
                     input ready);
    modport sink (input valid, start_x, start_y, start_z, dest_x, dest_y, dest_z,
                  output ready);
endinterface

[src/qbv_quat_if.sv]
interface qbv_quat_if;
    logic                                valid;
    logic                                ready;
    logic signed [qbv_pkg::OUT_W-1:0]    quat_w;
    logic signed [qbv_pkg::OUT_W-1:0]    quat_x;
    logic signed [qbv_pkg::OUT_W-1:0]    quat_y;
    logic signed [qbv_pkg::OUT_W-1:0]    quat_z;
    logic                                opposite_case;
    logic                                degenerate;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, opposite_case, degenerate,
                     input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, opposite_case, degenerate,
                  output ready);
endinterface

[src/qbv_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
module qbv_sqrt_pipe #(
    parameter int NW = 62,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   radicand,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [NW/2-1:0] root,
    output logic [SW-1:0]   side_out
);
    localparam int S  = NW / 2;
    localparam int RW = S + 2;

    logic          valid_reg [S];
    logic [S-1:0]  root_reg  [S];
    logic [RW-1:0] rem_reg   [S];
    logic [NW-1:0] rad_reg   [S];
    logic [SW-1:0] side_reg  [S];

    for (genvar i = 0; i < S; i++) begin : g_stage
        logic          valid_prev;
        logic [S-1:0]  root_prev;
        logic [RW-1:0] rem_prev;
        logic [NW-1:0] rad_prev;
        logic [SW-1:0] side_prev;
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic          fits;

        if (i == 0) begin : g_first
            assign valid_prev = in_valid;
            assign root_prev  = '0;
            assign rem_prev   = '0;
            assign rad_prev   = radicand;
            assign side_prev  = side_in;
        end
        else begin : g_rest
            assign valid_prev = valid_reg[i-1];
            assign root_prev  = root_reg[i-1];
            assign rem_prev   = rem_reg[i-1];
            assign rad_prev   = rad_reg[i-1];
            assign side_prev  = side_reg[i-1];
        end

        assign rem_sh = {rem_prev, rad_prev[NW-1 -: 2]};
        assign trial  = {2'b00, root_prev, 2'b01};
        assign fits   = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[i] <= {root_prev[S-2:0], fits};
                rem_reg[i]  <= fits ? RW'(rem_sh - trial) : RW'(rem_sh);
                rad_reg[i]  <= rad_prev << 2;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[S-1];
    assign root      = root_reg[S-1];
    assign side_out  = side_reg[S-1];
endmodule

[src/qbv_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
// The upper DW bits of the numerator must be below the divisor.
module qbv_div_pipe #(
    parameter int DW = 31,
    parameter int QW = 22,
    parameter int SW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DW+QW-1:0] numer,
    input  logic [DW-1:0]    denom,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [QW-1:0]    quot,
    output logic [SW-1:0]    side_out
);
    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] qx_reg    [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [SW-1:0] side_reg  [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic          valid_prev;
        logic [DW-1:0] rem_prev;
        logic [QW-1:0] qx_prev;
        logic [DW-1:0] den_prev;
        logic [SW-1:0] side_prev;
        logic [DW:0]   trial;
        logic          fits;

        if (i == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = numer[DW+QW-1:QW];
            assign qx_prev    = numer[QW-1:0];
            assign den_prev   = denom;
            assign side_prev  = side_in;
        end
        else begin : g_rest
            assign valid_prev = valid_reg[i-1];
            assign rem_prev   = rem_reg[i-1];
            assign qx_prev    = qx_reg[i-1];
            assign den_prev   = den_reg[i-1];
            assign side_prev  = side_reg[i-1];
        end

        // Numerator bits leave the top of qx while quotient bits enter below.
        assign trial = {rem_prev, qx_prev[QW-1]};
        assign fits  = trial >= {1'b0, den_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fits ? DW'(trial - {1'b0, den_prev}) : DW'(trial);
                qx_reg[i]   <= {qx_prev[QW-2:0], fits};
                den_reg[i]  <= den_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = qx_reg[QW-1];
    assign side_out  = side_reg[QW-1];
endmodule

[src/quaternion_between_vectors.sv]
// Channel  Dir  Contents
// pair     in   start_x/y/z, dest_x/y/z, signed Q12.12
// result   out  quat_w/x/y/z Q2.14, opposite_case, degenerate
//
// One transaction enters per cycle while the output register is empty or taken.
// A pair passes through two 31-stage square roots in series, the 31-stage
// normalizing divider and the 22-stage output divider.
// Reset clears all valid bits; data registers are not reset.
// When the output register is full and not taken, the whole pipeline holds.
module quaternion_between_vectors (
    input logic        clk,
    input logic        rst_n,
    qbv_pair_if.sink   pair,
    qbv_quat_if.source result
);
    function automatic logic [47:0] sq24(logic signed [23:0] v);
        logic signed [47:0] e;
        e = 48'(v);
        return 48'(e * e);
    endfunction

    function automatic logic signed [63:0] mul32(logic signed [31:0] x, logic signed [31:0] y);
        return 64'(x) * 64'(y);
    endfunction

    logic adv;

    // Stage 1: squared lengths.
    logic               s1_valid_reg;
    logic signed [23:0] s1_a_reg [3];
    logic signed [23:0] s1_b_reg [3];
    logic [47:0]        s1_sqa_reg, s1_sqb_reg;
    logic               s1_za_reg, s1_zb_reg;

    // Square roots of the lengths.
    logic        sa_valid;
    logic [30:0] sa_len, sb_len;
    logic [73:0] sa_side;
    logic [71:0] sb_side;

    // Normalizing numerators.
    logic        c_valid_reg;
    logic [61:0] c_num_reg [6];
    logic [61:0] c_num_next [6];
    logic        c_neg_reg [6];
    logic        c_neg_next [6];
    logic [30:0] c_len_reg [2];
    logic        c_deg_reg;

    logic        n_valid [6];
    logic [30:0] n_q [6];
    logic [1:0]  n_side [6];

    // Unit vectors, Q2.30.
    logic               e_valid_reg;
    logic signed [31:0] e_u_reg [6];
    logic signed [31:0] e_u_next [6];
    logic               e_deg_reg;

    // Products.
    logic               f_valid_reg;
    logic signed [63:0] f_p_reg [9];
    logic signed [63:0] f_sq_reg [3];
    logic signed [31:0] f_s_reg [3];
    logic               f_deg_reg;

    // Sums.
    logic               g_valid_reg;
    logic signed [63:0] g_dot_reg;
    logic signed [63:0] g_c_reg [3];
    logic [61:0]        g_sq1_reg, g_sq2_reg;
    logic signed [31:0] g_s_reg [3];
    logic               g_deg_reg;

    // Dot magnitude and axis choice.
    logic               h1_valid_reg;
    logic [63:0]        h1_dabs_reg;
    logic               h1_dneg_reg;
    logic signed [63:0] h1_c_reg [3];
    logic [61:0]        h1_sqax_reg;
    logic [30:0]        h1_am_reg [3];
    logic [30:0]        h1_am_next [3];
    logic               h1_an_reg [3];
    logic               h1_an_next [3];
    logic [30:0]        h1_sabs [3];
    logic               h1_sel;
    logic               h1_deg_reg;

    // Cosine magnitude and cross magnitudes.
    logic        h2_valid_reg;
    logic [30:0] h2_cosm_reg;
    logic [64:0] h2_rsum;
    logic [34:0] h2_rq;
    logic        h2_dneg_reg;
    logic [61:0] h2_cm_reg [3];
    logic        h2_cn_reg [3];
    logic [61:0] h2_sqax_reg;
    logic [30:0] h2_am_reg [3];
    logic        h2_an_reg [3];
    logic        h2_deg_reg;

    // Opposite test and half angle term.
    logic        h3_valid_reg;
    logic        h3_opp_reg;
    logic [30:0] h3_h_reg;
    logic [31:0] h3_hsum;
    logic [61:0] h3_cm_reg [3];
    logic        h3_cn_reg [3];
    logic [61:0] h3_sqax_reg;
    logic [30:0] h3_am_reg [3];
    logic        h3_an_reg [3];
    logic        h3_deg_reg;

    logic         sw_valid;
    logic [30:0]  sw_root, sx_root;
    logic [190:0] sw_side;
    logic [95:0]  sx_side;

    // Quotient setup.
    logic        p_valid_reg;
    logic [52:0] p_num_reg [3];
    logic [52:0] p_num_next [3];
    logic [30:0] p_den_reg;
    logic [19:0] p_side_reg [3];
    logic [19:0] p_side_next [3];
    logic [30:0] p_wf;
    logic [15:0] p_wq;
    logic        p_opp, p_deg, p_lz;

    logic        m_valid [3];
    logic [21:0] m_q [3];
    logic [19:0] m_side [3];

    // Output register.
    logic        out_valid_reg;
    logic [15:0] out_w_reg, out_x_reg, out_y_reg, out_z_reg;
    logic        out_opp_reg, out_deg_reg;
    logic [15:0] out_w_next;
    logic [15:0] out_v_next [3];
    logic [15:0] comp [3];
    logic [15:0] wmag;

    assign adv          = !out_valid_reg || result.ready;
    assign pair.ready   = adv;
    assign result.valid = out_valid_reg;
    assign result.quat_w        = out_w_reg;
    assign result.quat_x        = out_x_reg;
    assign result.quat_y        = out_y_reg;
    assign result.quat_z        = out_z_reg;
    assign result.opposite_case = out_opp_reg;
    assign result.degenerate    = out_deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            c_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h1_valid_reg  <= 1'b0;
            h2_valid_reg  <= 1'b0;
            h3_valid_reg  <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pair.valid;
            c_valid_reg   <= sa_valid;
            e_valid_reg   <= n_valid[0];
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= f_valid_reg;
            h1_valid_reg  <= g_valid_reg;
            h2_valid_reg  <= h1_valid_reg;
            h3_valid_reg  <= h2_valid_reg;
            p_valid_reg   <= sw_valid;
            out_valid_reg <= m_valid[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg[0] <= pair.start_x;
            s1_a_reg[1] <= pair.start_y;
            s1_a_reg[2] <= pair.start_z;
            s1_b_reg[0] <= pair.dest_x;
            s1_b_reg[1] <= pair.dest_y;
            s1_b_reg[2] <= pair.dest_z;
            s1_sqa_reg  <= sq24(pair.start_x) + sq24(pair.start_y) + sq24(pair.start_z);
            s1_sqb_reg  <= sq24(pair.dest_x) + sq24(pair.dest_y) + sq24(pair.dest_z);
            s1_za_reg   <= pair.start_x == '0 && pair.start_y == '0 && pair.start_z == '0;
            s1_zb_reg   <= pair.dest_x == '0 && pair.dest_y == '0 && pair.dest_z == '0;
        end
    end

    qbv_sqrt_pipe #(.NW(62), .SW(74)) u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s1_valid_reg),
        .radicand  ({s1_sqa_reg, 14'b0}),
        .side_in   ({s1_a_reg[0], s1_a_reg[1], s1_a_reg[2], s1_za_reg, s1_zb_reg}),
        .out_valid (sa_valid),
        .root      (sa_len),
        .side_out  (sa_side)
    );

    qbv_sqrt_pipe #(.NW(62), .SW(72)) u_sqrt_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s1_valid_reg),
        .radicand  ({s1_sqb_reg, 14'b0}),
        .side_in   ({s1_b_reg[0], s1_b_reg[1], s1_b_reg[2]}),
        .out_valid (),
        .root      (sb_len),
        .side_out  (sb_side)
    );

    always_comb
    begin
        logic [23:0] v;
        logic [23:0] mag;
        logic [30:0] len;
        for (int k = 0; k < 6; k++)
        begin
            v   = (k < 3) ? sa_side[73-24*k -: 24] : sb_side[71-24*(k-3) -: 24];
            len = (k < 3) ? sa_len : sb_len;
            mag = v[23] ? 24'(-v) : v;
            c_neg_next[k] = v[23];
            c_num_next[k] = 62'({mag, 37'b0}) + 62'(len >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_num_reg    <= c_num_next;
            c_neg_reg    <= c_neg_next;
            c_len_reg[0] <= sa_len;
            c_len_reg[1] <= sb_len;
            c_deg_reg    <= sa_side[1] | sa_side[0];
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_norm
        qbv_div_pipe #(.DW(31), .QW(31), .SW(2)) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (c_valid_reg),
            .numer     (c_num_reg[k]),
            .denom     (c_len_reg[k/3]),
            .side_in   ({c_neg_reg[k], c_deg_reg}),
            .out_valid (n_valid[k]),
            .quot      (n_q[k]),
            .side_out  (n_side[k])
        );
    end

    always_comb
    begin
        logic [30:0] qc;
        for (int k = 0; k < 6; k++)
        begin
            qc = (n_q[k] > qbv_pkg::ONE30) ? qbv_pkg::ONE30 : n_q[k];
            e_u_next[k] = n_side[k][1] ? -$signed(32'(qc)) : $signed(32'(qc));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_u_reg   <= e_u_next;
            e_deg_reg <= n_side[0][0];

            f_p_reg[0]  <= mul32(e_u_reg[0], e_u_reg[3]);
            f_p_reg[1]  <= mul32(e_u_reg[1], e_u_reg[4]);
            f_p_reg[2]  <= mul32(e_u_reg[2], e_u_reg[5]);
            f_p_reg[3]  <= mul32(e_u_reg[1], e_u_reg[5]);
            f_p_reg[4]  <= mul32(e_u_reg[2], e_u_reg[4]);
            f_p_reg[5]  <= mul32(e_u_reg[2], e_u_reg[3]);
            f_p_reg[6]  <= mul32(e_u_reg[0], e_u_reg[5]);
            f_p_reg[7]  <= mul32(e_u_reg[0], e_u_reg[4]);
            f_p_reg[8]  <= mul32(e_u_reg[1], e_u_reg[3]);
            f_sq_reg[0] <= mul32(e_u_reg[0], e_u_reg[0]);
            f_sq_reg[1] <= mul32(e_u_reg[1], e_u_reg[1]);
            f_sq_reg[2] <= mul32(e_u_reg[2], e_u_reg[2]);
            f_s_reg[0]  <= e_u_reg[0];
            f_s_reg[1]  <= e_u_reg[1];
            f_s_reg[2]  <= e_u_reg[2];
            f_deg_reg   <= e_deg_reg;

            g_dot_reg  <= f_p_reg[0] + f_p_reg[1] + f_p_reg[2];
            g_c_reg[0] <= f_p_reg[3] - f_p_reg[4];
            g_c_reg[1] <= f_p_reg[5] - f_p_reg[6];
            g_c_reg[2] <= f_p_reg[7] - f_p_reg[8];
            g_sq1_reg  <= 62'(f_sq_reg[0] + f_sq_reg[1]);
            g_sq2_reg  <= 62'(f_sq_reg[1] + f_sq_reg[2]);
            g_s_reg    <= f_s_reg;
            g_deg_reg  <= f_deg_reg;
        end
    end

    // The first axis is cross(z, start); when it is too short the block
    // falls back to cross(x, start).
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h1_sabs[k] = g_s_reg[k][31] ? 31'(-g_s_reg[k]) : 31'(g_s_reg[k]);
        end
        h1_sel = g_sq1_reg < qbv_pkg::AXIS_MIN_SQ;
        if (h1_sel)
        begin
            h1_am_next[0] = '0;
            h1_an_next[0] = 1'b0;
            h1_am_next[1] = h1_sabs[2];
            h1_an_next[1] = !g_s_reg[2][31] && g_s_reg[2] != '0;
            h1_am_next[2] = h1_sabs[1];
            h1_an_next[2] = g_s_reg[1][31];
        end
        else
        begin
            h1_am_next[0] = h1_sabs[1];
            h1_an_next[0] = !g_s_reg[1][31] && g_s_reg[1] != '0;
            h1_am_next[1] = h1_sabs[0];
            h1_an_next[1] = g_s_reg[0][31];
            h1_am_next[2] = '0;
            h1_an_next[2] = 1'b0;
        end
    end

    assign h2_rsum = 65'(h1_dabs_reg) + 65'(64'd536870912);
    assign h2_rq   = h2_rsum[64:30];
    assign h3_hsum = h2_dneg_reg ? 32'(qbv_pkg::ONE30) - 32'(h2_cosm_reg)
                                 : 32'(qbv_pkg::ONE30) + 32'(h2_cosm_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_dneg_reg <= g_dot_reg[63];
            h1_dabs_reg <= g_dot_reg[63] ? 64'(-g_dot_reg) : 64'(g_dot_reg);
            h1_c_reg    <= g_c_reg;
            h1_sqax_reg <= h1_sel ? g_sq2_reg : g_sq1_reg;
            h1_am_reg   <= h1_am_next;
            h1_an_reg   <= h1_an_next;
            h1_deg_reg  <= g_deg_reg;

            h2_cosm_reg <= (h2_rq > 35'(qbv_pkg::ONE30)) ? qbv_pkg::ONE30 : h2_rq[30:0];
            h2_dneg_reg <= h1_dneg_reg;
            for (int k = 0; k < 3; k++)
            begin
                h2_cm_reg[k] <= h1_c_reg[k][63] ? 62'(-h1_c_reg[k]) : 62'(h1_c_reg[k]);
                h2_cn_reg[k] <= h1_c_reg[k][63];
            end
            h2_sqax_reg <= h1_sqax_reg;
            h2_am_reg   <= h1_am_reg;
            h2_an_reg   <= h1_an_reg;
            h2_deg_reg  <= h1_deg_reg;

            h3_opp_reg  <= h2_dneg_reg && (h2_cosm_reg > qbv_pkg::OPP_LIM);
            h3_h_reg    <= h3_hsum[31:1];
            h3_cm_reg   <= h2_cm_reg;
            h3_cn_reg   <= h2_cn_reg;
            h3_sqax_reg <= h2_sqax_reg;
            h3_am_reg   <= h2_am_reg;
            h3_an_reg   <= h2_an_reg;
            h3_deg_reg  <= h2_deg_reg;
        end
    end

    qbv_sqrt_pipe #(.NW(62), .SW(191)) u_sqrt_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (h3_valid_reg),
        .radicand  ({1'b0, h3_h_reg, 30'b0}),
        .side_in   ({h3_cm_reg[0], h3_cm_reg[1], h3_cm_reg[2],
                     h3_cn_reg[0], h3_cn_reg[1], h3_cn_reg[2], h3_opp_reg, h3_deg_reg}),
        .out_valid (sw_valid),
        .root      (sw_root),
        .side_out  (sw_side)
    );

    qbv_sqrt_pipe #(.NW(62), .SW(96)) u_sqrt_ax (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (h3_valid_reg),
        .radicand  (h3_sqax_reg),
        .side_in   ({h3_am_reg[0], h3_am_reg[1], h3_am_reg[2],
                     h3_an_reg[0], h3_an_reg[1], h3_an_reg[2]}),
        .out_valid (),
        .root      (sx_root),
        .side_out  (sx_side)
    );

    // Both branches share the output dividers: the opposite case divides the
    // axis by its length, the normal case divides the cross product by 2w.
    assign p_wf  = (sw_root == '0) ? 31'd1 : sw_root;
    assign p_wq  = 16'((32'(p_wf) + 32'd32768) >> 16);
    assign p_opp = sw_side[1];
    assign p_deg = sw_side[0];
    assign p_lz  = sx_root == '0;

    always_comb
    begin
        logic [62:0] nsum;
        logic [45:0] nrm;
        logic [45:0] axn;
        logic        neg;
        for (int k = 0; k < 3; k++)
        begin
            nsum = 63'(sw_side[190-62*k -: 62]) + 63'({p_wf, 16'b0});
            nrm  = nsum[62:17];
            axn  = 46'({sx_side[95-31*k -: 31], 14'b0}) + 46'(sx_root >> 1);
            neg  = p_opp ? sx_side[2-k] : sw_side[4-k];
            p_num_next[k]  = 53'(p_opp ? axn : nrm);
            p_side_next[k] = {neg, p_opp, p_deg, p_lz, p_wq};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_num_reg  <= p_num_next;
            p_side_reg <= p_side_next;
            p_den_reg  <= p_opp ? sx_root : p_wf;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_quot
        qbv_div_pipe #(.DW(31), .QW(22), .SW(20)) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (p_valid_reg),
            .numer     (p_num_reg[k]),
            .denom     (p_den_reg),
            .side_in   (p_side_reg[k]),
            .out_valid (m_valid[k]),
            .quot      (m_q[k]),
            .side_out  (m_side[k])
        );
    end

    always_comb
    begin
        logic [15:0] mag;
        for (int k = 0; k < 3; k++)
        begin
            mag     = (m_q[k] > 22'(qbv_pkg::Q14_ONE)) ? qbv_pkg::Q14_ONE : m_q[k][15:0];
            comp[k] = m_side[k][19] ? 16'(-mag) : mag;
        end
        wmag = (m_side[0][15:0] > qbv_pkg::Q14_ONE) ? qbv_pkg::Q14_ONE : m_side[0][15:0];

        if (m_side[0][17])
        begin
            out_w_next    = qbv_pkg::Q14_ONE;
            out_v_next[0] = '0;
            out_v_next[1] = '0;
            out_v_next[2] = '0;
        end
        else if (m_side[0][18])
        begin
            out_w_next = '0;
            if (m_side[0][16])
            begin
                out_v_next[0] = qbv_pkg::Q14_ONE;
                out_v_next[1] = '0;
                out_v_next[2] = '0;
            end
            else
            begin
                out_v_next = comp;
            end
        end
        else
        begin
            out_w_next = wmag;
            out_v_next = comp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_w_reg   <= out_w_next;
            out_x_reg   <= out_v_next[0];
            out_y_reg   <= out_v_next[1];
            out_z_reg   <= out_v_next[2];
            out_opp_reg <= m_side[0][18] && !m_side[0][17];
            out_deg_reg <= m_side[0][17];
        end
    end
endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint OPP_EPS   = 64'sd1073742;
    localparam longint AXIS_SQ   = 64'sd115292150460685;
    localparam longint ONE_Q14   = 64'sd16384;
    localparam int     LATENCY   = 125;
    localparam int     CYCLE_MAX = 400000;

    typedef logic signed [qbv_pkg::IN_W-1:0] coord_t;
    typedef longint vec3_t[3];

    typedef struct {
        coord_t sx, sy, sz, dx, dy, dz;
    } pair_t;

    typedef struct {
        logic signed [qbv_pkg::OUT_W-1:0] w, x, y, z;
        logic                             opp, deg;
    } quat_t;

    logic clk;
    logic rst_n;

    qbv_pair_if pair ();
    qbv_quat_if result ();

    quaternion_between_vectors dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .result (result)
    );

    quat_t  pending_quats[$];
    int     error_count;
    int     cycle_count;
    int     burst_left;
    int     stall_phase;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Rounds to nearest with halves away from zero.
    function automatic longint round_div(longint num, longint unsigned den);
        logic            neg;
        longint unsigned mag;
        longint unsigned q;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        q = (mag + den / 2) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic logic to_unit(input vec3_t v, output vec3_t u);
        longint unsigned sq;
        longint unsigned len;
        longint unsigned mag;
        longint unsigned q;
        sq = 0;
        for (int i = 0; i < 3; i++)
            sq += longint'(v[i] * v[i]);
        u = '{0, 0, 0};
        if (sq == 0)
            return 1'b0;
        len = int_sqrt(sq << 14);
        if (len == 0)
            len = 1;
        for (int i = 0; i < 3; i++)
        begin
            mag = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            q = ((mag << 37) + len / 2) / len;
            u[i] = sat((v[i] < 0) ? -longint'(q) : longint'(q), ONE_Q30);
        end
        return 1'b1;
    endfunction

    function automatic quat_t pack_quat(longint w, longint x, longint y, longint z,
                                        logic opp, logic deg);
        quat_t q;
        q.w = 16'(sat(w, ONE_Q14));
        q.x = 16'(sat(x, ONE_Q14));
        q.y = 16'(sat(y, ONE_Q14));
        q.z = 16'(sat(z, ONE_Q14));
        q.opp = opp;
        q.deg = deg;
        return q;
    endfunction

    function automatic quat_t shortest_arc(pair_t p);
        vec3_t           a, b, s, d, ax, c;
        longint          dot60, cos30;
        longint unsigned sq, len, h, w30, den;
        logic            ok_s, ok_d;
        a = '{longint'(p.sx), longint'(p.sy), longint'(p.sz)};
        b = '{longint'(p.dx), longint'(p.dy), longint'(p.dz)};
        ok_s = to_unit(a, s);
        ok_d = to_unit(b, d);
        if (!ok_s || !ok_d)
            return pack_quat(ONE_Q14, 0, 0, 0, 1'b0, 1'b1);
        dot60 = s[0] * d[0] + s[1] * d[1] + s[2] * d[2];
        cos30 = sat(round_div(dot60, ONE_Q30), ONE_Q30);
        if (cos30 < -ONE_Q30 + OPP_EPS)
        begin
            ax = '{-s[1], s[0], 0};
            sq = longint'(ax[0] * ax[0]) + longint'(ax[1] * ax[1]);
            if (sq < AXIS_SQ)
            begin
                ax = '{0, -s[2], s[1]};
                sq = longint'(ax[1] * ax[1]) + longint'(ax[2] * ax[2]);
            end
            len = int_sqrt(sq);
            if (len == 0)
                return pack_quat(0, ONE_Q14, 0, 0, 1'b1, 1'b0);
            return pack_quat(0, round_div(ax[0] * 16384, len),
                             round_div(ax[1] * 16384, len),
                             round_div(ax[2] * 16384, len), 1'b1, 1'b0);
        end
        c[0] = s[1] * d[2] - s[2] * d[1];
        c[1] = s[2] * d[0] - s[0] * d[2];
        c[2] = s[0] * d[1] - s[1] * d[0];
        h = longint'(ONE_Q30 + cos30) >> 1;
        w30 = int_sqrt(h << 30);
        if (w30 == 0)
            w30 = 1;
        den = w30 << 17;
        return pack_quat(round_div(longint'(w30), 64'd65536), round_div(c[0], den),
                         round_div(c[1], den), round_div(c[2], den), 1'b0, 1'b0);
    endfunction

    task automatic report(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send_pair(pair_t p);
        pair.valid   = 1'b1;
        pair.start_x = p.sx;
        pair.start_y = p.sy;
        pair.start_z = p.sz;
        pair.dest_x  = p.dx;
        pair.dest_y  = p.dy;
        pair.dest_z  = p.dz;
        do
            @(posedge clk);
        while (!pair.ready);
        pending_quats.push_back(shortest_arc(p));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                pair.valid = 1'b0;
                repeat ($urandom_range(1, 6))
                    @(negedge clk);
            end
        end
    endtask

    task automatic send_vecs(longint sx, longint sy, longint sz,
                             longint dx, longint dy, longint dz);
        pair_t p;
        p.sx = coord_t'(sx);
        p.sy = coord_t'(sy);
        p.sz = coord_t'(sz);
        p.dx = coord_t'(dx);
        p.dy = coord_t'(dy);
        p.dz = coord_t'(dz);
        send_pair(p);
    endtask

    task automatic wait_drained();
        pair.valid = 1'b0;
        while (pending_quats.size() != 0)
            @(negedge clk);
    endtask

    function automatic longint clip24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint rand_coord(int range_sel);
        case (range_sel)
            0: return longint'($signed($urandom_range(0, 16777215) - 8388608));
            1: return longint'($urandom_range(0, 30)) - 15;
            2: return longint'($urandom_range(0, 8191)) - 4096;
            default: return longint'($urandom_range(0, 2097151)) - 1048576;
        endcase
    endfunction

    task automatic test_degenerate();
        send_vecs(0, 0, 0, 4096, 0, 0);
        send_vecs(4096, 0, 0, 0, 0, 0);
        send_vecs(0, 0, 0, 0, 0, 0);
        send_vecs(1, 0, 0, 0, 0, 0);
    endtask

    task automatic test_aligned();
        send_vecs(4096, 0, 0, 4096, 0, 0);
        send_vecs(4096, 0, 0, 0, 4096, 0);
        send_vecs(0, 0, 4096, 0, 4096, 0);
        send_vecs(1, 2, 3, 300, 200, 100);
        send_vecs(1, 0, 0, 8388607, 0, 0);
    endtask

    task automatic test_opposite();
        send_vecs(4096, 0, 0, -4096, 0, 0);
        send_vecs(0, 4096, 0, 0, -8192, 0);
        // Start along z: the first axis vanishes and the x-based axis is used.
        send_vecs(0, 0, 4096, 0, 0, -4096);
        send_vecs(0, 0, -8388608, 0, 0, 8388607);
        send_vecs(3, -5, 7, -3, 5, -7);
        send_vecs(100000, 1, 0, -100000, 0, 0);
        send_vecs(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
    endtask

    task automatic test_extremes();
        send_vecs(8388607, 8388607, 8388607, -8388608, 8388607, -8388608);
        send_vecs(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
        send_vecs(-1, -1, -1, 1, -1, 1);
        send_vecs(8388607, -8388608, 1, -1, 0, 8388607);
        send_vecs(-8388608, 0, 0, 0, 0, -1);
        wait_drained();
    endtask

    task automatic test_random(int count);
        pair_t  p;
        longint sx, sy, sz;
        int     mode, rs;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            rs = $urandom_range(0, 3);
            sx = rand_coord(rs);
            sy = rand_coord(rs);
            sz = rand_coord(rs);
            p.sx = coord_t'(sx);
            p.sy = coord_t'(sy);
            p.sz = coord_t'(sz);
            if (mode <= 4)
            begin
                rs = $urandom_range(0, 3);
                p.dx = coord_t'(rand_coord(rs));
                p.dy = coord_t'(rand_coord(rs));
                p.dz = coord_t'(rand_coord(rs));
            end
            else if (mode <= 7)
            begin
                // Nearly opposite: negate with a small disturbance.
                p.dx = coord_t'(clip24(-sx + longint'($urandom_range(0, 6)) - 3));
                p.dy = coord_t'(clip24(-sy + longint'($urandom_range(0, 6)) - 3));
                p.dz = coord_t'(clip24(-sz + longint'($urandom_range(0, 6)) - 3));
            end
            else if (mode == 8)
            begin
                p.dx = coord_t'(clip24(sx + longint'($urandom_range(0, 2)) - 1));
                p.dy = coord_t'(clip24(sy));
                p.dz = coord_t'(clip24(sz + longint'($urandom_range(0, 2)) - 1));
            end
            else
            begin
                p.dx = coord_t'(rand_coord(0));
                p.dy = coord_t'(rand_coord(0));
                p.dz = coord_t'(rand_coord(0));
                if ($urandom_range(0, 1) != 0)
                    {p.sx, p.sy, p.sz} = '0;
                else
                    {p.dx, p.dy, p.dz} = '0;
            end
            send_pair(p);
            if (n == count / 2)
                wait_drained();
        end
    endtask

    always @(negedge clk)
    begin
        stall_phase = (stall_phase + 1) % 200;
        if (stall_phase < 40)
            result.ready = 1'b1;
        else if (stall_phase < 60)
            result.ready = (stall_phase % 5) == 0;
        else
            result.ready = $urandom_range(0, 3) != 0;
    end

    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_quats.size() == 0)
                report("result with no pending pair");
            else
            begin
                want = pending_quats.pop_front();
                if (result.quat_w !== want.w)
                    report($sformatf("quat_w %0d, want %0d", result.quat_w, want.w));
                if (result.quat_x !== want.x)
                    report($sformatf("quat_x %0d, want %0d", result.quat_x, want.x));
                if (result.quat_y !== want.y)
                    report($sformatf("quat_y %0d, want %0d", result.quat_y, want.y));
                if (result.quat_z !== want.z)
                    report($sformatf("quat_z %0d, want %0d", result.quat_z, want.z));
                if (result.opposite_case !== want.opp)
                    report($sformatf("opposite_case %b, want %b",
                                     result.opposite_case, want.opp));
                if (result.degenerate !== want.deg)
                    report($sformatf("degenerate %b, want %b",
                                     result.degenerate, want.deg));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_MAX)
        begin
            $display("timeout with %0d results outstanding", pending_quats.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        stall_phase = 0;
        rst_n = 1'b0;
        pair.valid = 1'b0;
        {pair.start_x, pair.start_y, pair.start_z} = '0;
        {pair.dest_x, pair.dest_y, pair.dest_z} = '0;
        result.ready = 1'b0;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_degenerate();
        test_aligned();
        test_opposite();
        test_extremes();
        test_random(500);

        wait_drained();
        repeat (LATENCY + 10)
            @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
